// ----- sv/uartbr_pkg.sv -----
// Shared types, register map constants and index helpers for the UART bridge register block.
package uartbr_pkg;

    localparam int FIFO_DEPTH = 64;
    localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
    localparam logic [FIFO_IDX_W-1:0] FIFO_LAST_IDX = FIFO_IDX_W'(FIFO_DEPTH - 1);

    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_POINTER = 2'd1,
        OP_WRITE   = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    localparam logic [7:0] PTR_HOLD = 8'h00;
    localparam logic [7:0] PTR_IER  = 8'h08;
    localparam logic [7:0] PTR_LCR  = 8'h18;
    localparam logic [7:0] PTR_MCR  = 8'h20;
    localparam logic [7:0] PTR_LSR  = 8'h28;
    localparam logic [7:0] PTR_SPR  = 8'h38;

    localparam logic [7:0] LSR_READY = 8'h01;
    localparam logic [7:0] LSR_THRE  = 8'h20;
    localparam logic [7:0] LSR_TEMT  = 8'h40;
    localparam logic [7:0] NO_REG    = 8'hFF;

    typedef struct packed {
        op_t        operation;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic [7:0] tx_data;
        logic       tx_valid;
        logic       rts_level;
        logic       rx_overflow;
    } out_item_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] push_data;
    } fifo_cmd_t;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] head;
    } fifo_stat_t;

    // Ring index increment that also works for depths that are not a power of two.
    function automatic logic [FIFO_IDX_W-1:0] idx_inc(input logic [FIFO_IDX_W-1:0] idx);
        return (idx == FIFO_LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

endpackage

// ----- sv/uartbr_rx_fifo.sv -----
// Receive ring FIFO: byte memory, read and write indices, and a prefetched head entry.
module uartbr_rx_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  uartbr_pkg::fifo_cmd_t  cmd,
    output uartbr_pkg::fifo_stat_t stat
);
    import uartbr_pkg::*;

    logic [7:0]            mem [FIFO_DEPTH];
    logic [FIFO_IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [FIFO_IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]            head_reg;

    always_comb begin
        wr_idx_next = cmd.push ? idx_inc(wr_idx_reg) : wr_idx_reg;
        rd_idx_next = cmd.pop  ? idx_inc(rd_idx_reg) : rd_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    // The head entry is read ahead every cycle, so it always mirrors mem[rd_idx_reg].
    // A write landing on that same entry is forwarded.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[wr_idx_reg] <= cmd.push_data;
        end
        if (cmd.push && (wr_idx_reg == rd_idx_next)) begin
            head_reg <= cmd.push_data;
        end else begin
            head_reg <= mem[rd_idx_next];
        end
    end

    assign stat.empty = (wr_idx_reg == rd_idx_reg);
    assign stat.full  = (idx_inc(wr_idx_reg) == rd_idx_reg);
    assign stat.head  = head_reg;

endmodule

// ----- sv/uartbr_regs.sv -----
// Register file, pointer and event decode that form one result from one request.
module uartbr_regs (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   fire,
    input  uartbr_pkg::in_item_t   item,
    input  uartbr_pkg::fifo_stat_t fifo_stat,
    output uartbr_pkg::fifo_cmd_t  fifo_cmd,
    output uartbr_pkg::out_item_t  result
);
    import uartbr_pkg::*;

    logic [7:0] ptr_reg, ptr_next;
    logic [7:0] ier_reg, ier_next;
    logic [7:0] lcr_reg, lcr_next;
    logic [7:0] mcr_reg, mcr_next;
    logic [7:0] spr_reg, spr_next;

    always_comb begin
        ptr_next = ptr_reg;
        ier_next = ier_reg;
        lcr_next = lcr_reg;
        mcr_next = mcr_reg;
        spr_next = spr_reg;
        fifo_cmd = '0;
        fifo_cmd.push_data = item.byte_value;
        result = '0;

        unique case (item.operation)
            OP_RX_BYTE: begin
                if (fifo_stat.full) begin
                    result.rx_overflow = 1'b1;
                end else begin
                    fifo_cmd.push = fire;
                end
            end
            OP_POINTER: begin
                ptr_next = item.byte_value;
            end
            OP_WRITE: begin
                unique case (ptr_reg)
                    PTR_HOLD: begin
                        result.tx_data  = item.byte_value;
                        result.tx_valid = 1'b1;
                    end
                    PTR_IER: ier_next = item.byte_value;
                    PTR_LCR: lcr_next = item.byte_value;
                    PTR_MCR: mcr_next = item.byte_value;
                    PTR_SPR: spr_next = item.byte_value;
                    default: ;
                endcase
            end
            OP_READ: begin
                result.read_valid = 1'b1;
                unique case (ptr_reg)
                    PTR_HOLD: begin
                        if (!fifo_stat.empty) begin
                            result.read_data = fifo_stat.head;
                            fifo_cmd.pop     = fire;
                        end
                    end
                    PTR_LSR: result.read_data = LSR_THRE | LSR_TEMT |
                                                (fifo_stat.empty ? 8'h00 : LSR_READY);
                    PTR_IER: result.read_data = ier_reg;
                    PTR_LCR: result.read_data = lcr_reg;
                    PTR_MCR: result.read_data = mcr_reg;
                    PTR_SPR: result.read_data = spr_reg;
                    default: result.read_data = NO_REG;
                endcase
            end
            default: ;
        endcase

        result.rts_level = mcr_next[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
            ier_reg <= '0;
            lcr_reg <= '0;
            mcr_reg <= '0;
            spr_reg <= '0;
        end else if (fire) begin
            ptr_reg <= ptr_next;
            ier_reg <= ier_next;
            lcr_reg <= lcr_next;
            mcr_reg <= mcr_next;
            spr_reg <= spr_next;
        end
    end

endmodule

// ----- sv/bus_uart_bridge_registers_core.sv -----
// Top level of the UART bridge register block: request register, decode, result register.
//
// Each request is one event: a received UART byte, a bus pointer byte, a bus data write or a
// bus read, and each produces exactly one result. A request is taken into an input register,
// decoded by short logic against the register file and the receive FIFO, and its result is
// captured in an output register; state changes take effect as the request moves into the
// output register. One request is accepted per clock cycle in steady flow. m_valid rises at
// the clock edge after the request is accepted, as long as the output register is free or
// being drained. The receive FIFO has 64 entries and holds at most 63 bytes; its head entry
// is read ahead from the memory every cycle, which is what lets back-to-back FIFO reads run
// at full rate. A byte received while the FIFO is full is dropped and flagged with
// rx_overflow in its result. rts_level always shows bit 1 of the modem control register as
// it stands after the request. The FIFO memory needs no clearing after reset; only its
// indices are reset.
module bus_uart_bridge_registers_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  uartbr_pkg::in_item_t  s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output uartbr_pkg::out_item_t m_item
);
    import uartbr_pkg::*;

    logic       in_valid_reg, in_valid_next;
    in_item_t   in_item_reg;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg;
    logic       advance;
    out_item_t  result;
    fifo_cmd_t  fifo_cmd;
    fifo_stat_t fifo_stat;

    // The held request moves on whenever the output register is empty or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    uartbr_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .item      (in_item_reg),
        .fifo_stat (fifo_stat),
        .fifo_cmd  (fifo_cmd),
        .result    (result)
    );

    uartbr_rx_fifo u_rx_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (fifo_cmd),
        .stat    (fifo_stat)
    );

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

// ----- tb/sv/bus_uart_bridge_registers_core_tb.sv -----
// Self-checking testbench for the UART bridge register block, with its own response predictor.
module bus_uart_bridge_registers_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uartbr_pkg::*;

    // Watchdog bound on the run length, in clock cycles.
    localparam int CYCLE_LIMIT = 200000;
    // Random requests after the directed part and the FIFO fill and drain.
    localparam int RANDOM_REQUESTS = 650;
    // Receiver hold-off used to back the block up until it stalls its input.
    localparam int HOLD_OFF_CYCLES = 150;
    // Chance in a hundred that either side idles in a given cycle.
    localparam int IDLE_PERCENT = 38;
    // Margin waited after the last response, to catch any stray response.
    localparam int DRAIN_CYCLES = 8;
    // Mismatch lines beyond this count are still counted but no longer printed.
    localparam int PRINT_LIMIT = 40;

    // Pointers that a write can land on; the holding register transmits instead of storing.
    localparam logic [7:0] RW_POINTERS [5] = '{PTR_HOLD, PTR_IER, PTR_LCR, PTR_MCR, PTR_SPR};

    typedef enum int {
        BURST_RX,
        DRAIN_HOLD,
        REG_ACCESS,
        LINE_STATUS,
        RX_AND_READ,
        NOISE
    } burst_kind_t;

    // One row of the directed table. Rows with a typed-in response are checked against it;
    // the others are checked against the predictor.
    typedef struct {
        op_t        op;
        logic [7:0] value;
        bit         fixed;
        out_item_t  want;
    } plan_row_t;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Predictor state: receive FIFO, its ring indices, and the bus-visible registers.
    logic [7:0]            rx_bytes [FIFO_DEPTH];
    logic [FIFO_IDX_W-1:0] rx_wr_idx  = '0;
    logic [FIFO_IDX_W-1:0] rx_rd_idx  = '0;
    logic [7:0]            ptr_shadow = '0;
    logic [7:0]            ier_shadow = '0;
    logic [7:0]            lcr_shadow = '0;
    logic [7:0]            mcr_shadow = '0;
    logic [7:0]            spr_shadow = '0;

    // Responses predicted for accepted requests, oldest first.
    out_item_t pending_responses [$];
    plan_row_t directed_plan [$];

    int  requests_sent  = 0;
    int  responses_seen = 0;
    int  reads_seen     = 0;
    int  tx_seen        = 0;
    int  drops_seen     = 0;
    int  failures       = 0;
    int  cycle_count    = 0;
    // Both sides stop idling at random while this is set; a receiver hold-off still applies.
    bit  steady         = 1'b0;
    // The sender bumps this to ask the receiver for a hold-off; the receiver tracks its own
    // count of hold-offs served, so each variable has a single writer.
    int  hold_requests  = 0;
    int  holds_served   = 0;
    int  hold_left      = 0;

    bus_uart_bridge_registers_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Ring index step; the FIFO depth need not be a power of two.
    function automatic logic [FIFO_IDX_W-1:0] ring_next(input logic [FIFO_IDX_W-1:0] idx);
        return (idx == FIFO_IDX_W'(FIFO_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Applies one request to the predictor state and returns the response it must produce.
    // A ring of FIFO_DEPTH entries holds at most FIFO_DEPTH-1 bytes, so a received byte is
    // dropped when advancing the write index would make it catch up with the read index.
    function automatic out_item_t next_response(input in_item_t req);
        out_item_t             res;
        logic [FIFO_IDX_W-1:0] next_wr;
        logic                  has_data;
        res      = '0;
        has_data = (rx_wr_idx != rx_rd_idx);
        next_wr  = ring_next(rx_wr_idx);
        case (req.operation)
            OP_RX_BYTE: begin
                if (next_wr != rx_rd_idx) begin
                    rx_bytes[rx_wr_idx] = req.byte_value;
                    rx_wr_idx = next_wr;
                end else begin
                    res.rx_overflow = 1'b1;
                end
            end
            OP_POINTER: ptr_shadow = req.byte_value;
            OP_WRITE: begin
                // Writes to the line status or to an unmapped pointer change nothing.
                case (ptr_shadow)
                    PTR_HOLD: begin
                        res.tx_data  = req.byte_value;
                        res.tx_valid = 1'b1;
                    end
                    PTR_IER: ier_shadow = req.byte_value;
                    PTR_LCR: lcr_shadow = req.byte_value;
                    PTR_MCR: mcr_shadow = req.byte_value;
                    PTR_SPR: spr_shadow = req.byte_value;
                    default: ;
                endcase
            end
            OP_READ: begin
                res.read_valid = 1'b1;
                case (ptr_shadow)
                    PTR_HOLD: begin
                        // An empty FIFO reads as zero and leaves the indices alone.
                        if (has_data) begin
                            res.read_data = rx_bytes[rx_rd_idx];
                            rx_rd_idx = ring_next(rx_rd_idx);
                        end
                    end
                    PTR_LSR: res.read_data = LSR_THRE | LSR_TEMT | (has_data ? LSR_READY : 8'h00);
                    PTR_IER: res.read_data = ier_shadow;
                    PTR_LCR: res.read_data = lcr_shadow;
                    PTR_MCR: res.read_data = mcr_shadow;
                    PTR_SPR: res.read_data = spr_shadow;
                    default: res.read_data = NO_REG;
                endcase
            end
            default: ;
        endcase
        // RTS follows modem control bit 1 as it stands after the request.
        res.rts_level = mcr_shadow[1];
        return res;
    endfunction

    function automatic out_item_t outcome(input logic [7:0] rd, input logic rv,
                                          input logic [7:0] td, input logic tv,
                                          input logic rts);
        out_item_t res;
        res = '0;
        res.read_data  = rd;
        res.read_valid = rv;
        res.tx_data    = td;
        res.tx_valid   = tv;
        res.rts_level  = rts;
        return res;
    endfunction

    task automatic plan(input op_t op, input logic [7:0] value, input bit fixed,
                        input out_item_t want);
        plan_row_t row;
        row.op    = op;
        row.value = value;
        row.fixed = fixed;
        row.want  = want;
        directed_plan.push_back(row);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        failures++;
        if (failures <= PRINT_LIMIT)
            $display("mismatch on response %0d: %s got 0x%02h expected 0x%02h",
                     responses_seen, what, got, want);
    endtask

    // Compares one accepted response with the oldest prediction, field by field.
    task automatic check_response(input out_item_t got);
        out_item_t want;
        responses_seen++;
        if (pending_responses.size() == 0) begin
            report_mismatch("response with no request pending", got.read_data, 8'h00);
            return;
        end
        want = pending_responses.pop_front();
        if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
        if (got.read_valid !== want.read_valid)
            report_mismatch("read_valid", 8'(got.read_valid), 8'(want.read_valid));
        if (got.tx_data !== want.tx_data)
            report_mismatch("tx_data", got.tx_data, want.tx_data);
        if (got.tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
        if (got.rts_level !== want.rts_level)
            report_mismatch("rts_level", 8'(got.rts_level), 8'(want.rts_level));
        if (got.rx_overflow !== want.rx_overflow)
            report_mismatch("rx_overflow", 8'(got.rx_overflow), 8'(want.rx_overflow));
        if (got.read_valid === 1'b1) reads_seen++;
        if (got.tx_valid === 1'b1) tx_seen++;
        if (got.rx_overflow === 1'b1) drops_seen++;
    endtask

    // Response side. Outputs are sampled at the rising edge, before any update of that edge
    // lands, and m_ready is driven with a nonblocking assignment once per edge. A hold-off
    // request from the sender keeps m_ready low until the hold-off count runs out; otherwise the
    // receiver stalls at random unless the run is in a steady stretch.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_response(m_item);
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Offers one request, idling first at random, and waits for it to be accepted. The
    // request is fed to the predictor at the edge where it is taken. Valid is lowered only
    // in idle cycles, so a back-to-back request never sees valid dropped and raised in one
    // step.
    task automatic send_event(input in_item_t req, input bit fixed, input out_item_t want);
        out_item_t predicted;
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
        predicted = next_response(req);
        pending_responses.push_back(fixed ? want : predicted);
        requests_sent++;
    endtask

    task automatic send_op(input op_t op, input logic [7:0] value);
        in_item_t req;
        req.operation  = op;
        req.byte_value = value;
        send_event(req, 1'b0, '0);
    endtask

    // The sender pauses with valid low until every predicted response has come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge aclk);
    endtask

    // Random stimulus is built from short, well-formed sequences with random content: runs
    // of received bytes, drains through the holding register, register write and read-back,
    // status polls, receive traffic mixed with drains, and a little pure noise.
    task automatic run_burst(input burst_kind_t kind);
        int         n;
        logic [7:0] target;
        case (kind)
            BURST_RX: begin
                n = $urandom_range(1, 70);
                repeat (n) send_op(OP_RX_BYTE, 8'($urandom_range(255)));
            end
            DRAIN_HOLD: begin
                send_op(OP_POINTER, PTR_HOLD);
                n = $urandom_range(1, 70);
                repeat (n) send_op(OP_READ, 8'($urandom_range(255)));
            end
            REG_ACCESS: begin
                target = RW_POINTERS[$urandom_range(4)];
                send_op(OP_POINTER, target);
                send_op(OP_WRITE, 8'($urandom_range(255)));
                if ($urandom_range(3) == 0) send_op(OP_WRITE, 8'($urandom_range(255)));
                send_op(OP_READ, 8'($urandom_range(255)));
            end
            LINE_STATUS: begin
                send_op(OP_POINTER, PTR_LSR);
                send_op(OP_READ, 8'($urandom_range(255)));
            end
            RX_AND_READ: begin
                send_op(OP_POINTER, PTR_HOLD);
                n = $urandom_range(4, 40);
                repeat (n)
                    send_op($urandom_range(1) ? OP_RX_BYTE : OP_READ, 8'($urandom_range(255)));
            end
            default: begin
                n = $urandom_range(1, 8);
                repeat (n) send_op(op_t'($urandom_range(3)), 8'($urandom_range(255)));
            end
        endcase
    endtask

    initial begin : stimulus
        int          round;
        int          pick;
        int          random_base;
        burst_kind_t kind;
        in_item_t    req;

        // Synchronous reset, held low from time zero and then released.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. Responses typed in here follow directly from the register map:
        // reads after reset, transmit on a write before any pointer, line status values,
        // unmapped pointers, ignored writes and the RTS level.
        plan(OP_READ,    8'h00,    1'b1, outcome(8'h00, 1'b1, 8'h00, 1'b0, 1'b0));
        plan(OP_WRITE,   8'hA5,    1'b1, outcome(8'h00, 1'b0, 8'hA5, 1'b1, 1'b0));
        plan(OP_WRITE,   8'h00,    1'b1, outcome(8'h00, 1'b0, 8'h00, 1'b1, 1'b0));
        plan(OP_WRITE,   8'hFF,    1'b1, outcome(8'h00, 1'b0, 8'hFF, 1'b1, 1'b0));
        plan(OP_POINTER, PTR_LSR,  1'b1, outcome(8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
        plan(OP_READ,    8'hFF,    1'b1, outcome(8'h60, 1'b1, 8'h00, 1'b0, 1'b0));
        plan(OP_RX_BYTE, 8'h00,    1'b1, outcome(8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
        plan(OP_RX_BYTE, 8'hFF,    1'b1, outcome(8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
        plan(OP_READ,    8'h00,    1'b1, outcome(8'h61, 1'b1, 8'h00, 1'b0, 1'b0));
        plan(OP_POINTER, PTR_HOLD, 1'b0, '0);
        plan(OP_READ,    8'h00,    1'b0, '0);
        plan(OP_READ,    8'h00,    1'b0, '0);
        plan(OP_READ,    8'h00,    1'b1, outcome(8'h00, 1'b1, 8'h00, 1'b0, 1'b0));
        plan(OP_POINTER, PTR_MCR,  1'b0, '0);
        plan(OP_WRITE,   8'hFF,    1'b1, outcome(8'h00, 1'b0, 8'h00, 1'b0, 1'b1));
        plan(OP_READ,    8'h00,    1'b0, '0);
        plan(OP_POINTER, 8'hFF,    1'b1, outcome(8'h00, 1'b0, 8'h00, 1'b0, 1'b1));
        plan(OP_READ,    8'h00,    1'b1, outcome(NO_REG, 1'b1, 8'h00, 1'b0, 1'b1));
        plan(OP_WRITE,   8'h33,    1'b1, outcome(8'h00, 1'b0, 8'h00, 1'b0, 1'b1));
        plan(OP_POINTER, PTR_LSR,  1'b0, '0);
        plan(OP_WRITE,   8'h12,    1'b0, '0);
        plan(OP_POINTER, PTR_MCR,  1'b0, '0);
        plan(OP_WRITE,   8'h00,    1'b0, '0);
        plan(OP_POINTER, PTR_IER,  1'b0, '0);
        plan(OP_WRITE,   8'h5A,    1'b0, '0);
        plan(OP_READ,    8'h00,    1'b0, '0);

        foreach (directed_plan[i]) begin
            req.operation  = directed_plan[i].op;
            req.byte_value = directed_plan[i].value;
            send_event(req, directed_plan[i].fixed, directed_plan[i].want);
        end
        wait_idle();

        // Fill the receive FIFO past full while the receiver holds off, so that the block
        // backs up and stalls its input and the last received bytes are dropped.
        steady = 1'b1;
        hold_requests++;
        repeat (FIFO_DEPTH + 2) send_op(OP_RX_BYTE, 8'($urandom_range(255)));
        steady = 1'b0;
        wait_idle();

        // Drain it again, one read past empty.
        send_op(OP_POINTER, PTR_HOLD);
        repeat (FIFO_DEPTH) send_op(OP_READ, 8'($urandom_range(255)));

        // Random part, with a stretch of rounds in which neither side idles.
        random_base = requests_sent;
        round = 0;
        while (requests_sent - random_base < RANDOM_REQUESTS) begin
            steady = (round >= 20 && round < 32);
            pick = $urandom_range(99);
            if (pick < 22)      kind = BURST_RX;
            else if (pick < 40) kind = DRAIN_HOLD;
            else if (pick < 65) kind = REG_ACCESS;
            else if (pick < 73) kind = LINE_STATUS;
            else if (pick < 88) kind = RX_AND_READ;
            else                kind = NOISE;
            run_burst(kind);
            if (round == 45) hold_requests++;
            if ($urandom_range(9) == 0) wait_idle();
            round++;
        end
        steady = 1'b0;

        // Wait for every outstanding response, then a further margin for any stray one.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d responses to %0d requests: %0d bus reads, %0d transmit bytes,",
                 responses_seen, requests_sent, reads_seen, tx_seen);
        $display("%0d dropped receive bytes; FIFO filled past full and drained past empty.",
                 drops_seen);
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Guards against a hung handshake.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d responses pending",
                 cycle_count, pending_responses.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
